// File: rtl/smfb_pkg.sv
// ---------------------------------------------------------------------------
// SMBus MCTP frame builder package
// Shared types, codes and the CRC-8 helper used by the frame builder modules.
// ---------------------------------------------------------------------------
package smfb_pkg;

	// SMBus command code for MCTP over SMBus.
	localparam logic [7:0] CMD_CODE = 8'h0F;

	// CRC-8 polynomial x^8 + x^2 + x + 1 used for the packet error code.
	localparam logic [7:0] CRC_POLY = 8'h07;

	// Configuration register indexes and their reset values.
	localparam int unsigned CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_ADDRESS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TARGET_ADDRESS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_TARGET_ENABLED = 2'd2;

	localparam logic [6:0] SOURCE_ADDRESS_RST = 7'd24;
	localparam logic [6:0] TARGET_ADDRESS_RST = 7'd48;
	localparam logic       TARGET_ENABLED_RST = 1'b1;

	// Role of each frame byte on the output.
	typedef enum logic [2:0] {
		ROLE_CMD     = 3'd0,
		ROLE_COUNT   = 3'd1,
		ROLE_SOURCE  = 3'd2,
		ROLE_PAYLOAD = 3'd3,
		ROLE_PEC     = 3'd4
	} role_t;

	// Step of the framer while it works on the item in the input register.
	typedef enum logic [4:0] {
		PH_NEW  = 5'b00001,
		PH_CNT  = 5'b00010,
		PH_SRC  = 5'b00100,
		PH_DATA = 5'b01000,
		PH_PEC  = 5'b10000
	} phase_t;

	// Item held in the input register.
	typedef struct packed {
		logic       valid;
		logic [7:0] payload;
		logic       first;
		logic       last;
		logic [7:0] plen;
	} item_t;

	// Configuration seen by the framer.
	typedef struct packed {
		logic [6:0] src;
		logic [6:0] tgt;
		logic       en;
	} cfg_t;

	// One frame byte headed for the output register.
	typedef struct packed {
		logic       valid;
		logic [7:0] frame_byte;
		role_t      role;
		logic       frame_end;
		logic       mism;
	} res_t;

	// One byte through the CRC-8, most significant bit first.
	function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] data);
		logic [7:0] c;
		c = crc ^ data;
		for (int i = 0; i < 8; i++) begin
			c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
		end
		return c;
	endfunction

endpackage

// File: rtl/smfb_in_reg.sv
// ---------------------------------------------------------------------------
// SMBus MCTP frame builder input register
// Holds one packet byte until the framer has produced all of its frame bytes.
// ---------------------------------------------------------------------------
module smfb_in_reg (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [7:0]          payload_byte,
	input  logic                first_byte,
	input  logic                final_byte,
	input  logic [7:0]          packet_length,
	input  logic                done,
	output smfb_pkg::item_t     item
);

	logic       valid_q;
	logic [7:0] payload_q;
	logic       first_q;
	logic       last_q;
	logic [7:0] plen_q;
	logic       load;

	// The register takes a new item when it is empty or its item finishes now.
	assign load     = !valid_q || done;
	assign in_stall = !load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load && in_valid) begin
			payload_q <= payload_byte;
			first_q   <= first_byte;
			last_q    <= final_byte;
			plen_q    <= packet_length;
		end
	end

	always_comb begin
		item.valid   = valid_q;
		item.payload = payload_q;
		item.first   = first_q;
		item.last    = last_q;
		item.plen    = plen_q;
	end

endmodule

// File: rtl/smfb_framer.sv
// ---------------------------------------------------------------------------
// SMBus MCTP frame builder framer
// Packet state, running PEC and the step sequencer that turns a packet byte
// into its header, payload and PEC bytes, one per cycle unless out_ok is low.
// ---------------------------------------------------------------------------
module smfb_framer (
	input  logic                clk,
	input  logic                arst_n,
	input  smfb_pkg::item_t     item,
	input  smfb_pkg::cfg_t      cfg,
	input  logic                out_ok,
	output smfb_pkg::res_t      res,
	output logic                done
);

	smfb_pkg::phase_t phase_q, phase_d;
	logic [7:0] pec_q, pec_d;
	logic [7:0] seen_q, seen_d;
	logic [7:0] decl_q, decl_d;
	logic       in_frame_q, in_frame_d;
	logic       drop_q, drop_d;

	logic       start;
	logic       eff_in_frame;
	logic       eff_drop;
	logic [7:0] eff_seen;
	logic [7:0] eff_pec;
	logic [7:0] cnt;
	logic [7:0] src;
	logic       do_data;
	logic       emit;
	logic       fire;

	assign start = (phase_q == smfb_pkg::PH_NEW) && item.first;
	assign cnt   = item.plen + 8'd1;
	assign src   = {cfg.src, 1'b1};

	// A first byte opens a new packet in its first cycle, so the state it
	// sees is the freshly opened one.
	assign eff_in_frame = start ? 1'b1 : in_frame_q;
	assign eff_drop     = start ? !cfg.en : drop_q;
	assign eff_seen     = start ? 8'd0 : seen_q;
	assign eff_pec      = start ? (cfg.en ? smfb_pkg::crc8_step(8'd0, {cfg.tgt, 1'b0}) : 8'd0)
	                            : pec_q;

	always_comb begin
		phase_d        = smfb_pkg::PH_NEW;
		pec_d          = eff_pec;
		seen_d         = eff_seen;
		decl_d         = start ? item.plen : decl_q;
		in_frame_d     = eff_in_frame;
		drop_d         = eff_drop;
		do_data        = 1'b0;
		emit           = 1'b0;
		res.frame_byte = item.payload;
		res.role       = smfb_pkg::ROLE_PAYLOAD;
		res.frame_end  = 1'b0;
		res.mism       = 1'b0;

		case (phase_q)
			smfb_pkg::PH_NEW: begin
				if (start && cfg.en) begin
					emit           = 1'b1;
					res.frame_byte = smfb_pkg::CMD_CODE;
					res.role       = smfb_pkg::ROLE_CMD;
					pec_d          = smfb_pkg::crc8_step(eff_pec, smfb_pkg::CMD_CODE);
					phase_d        = smfb_pkg::PH_CNT;
				end else begin
					do_data = 1'b1;
				end
			end
			smfb_pkg::PH_CNT: begin
				emit           = 1'b1;
				res.frame_byte = cnt;
				res.role       = smfb_pkg::ROLE_COUNT;
				pec_d          = smfb_pkg::crc8_step(pec_q, cnt);
				phase_d        = smfb_pkg::PH_SRC;
			end
			smfb_pkg::PH_SRC: begin
				emit           = 1'b1;
				res.frame_byte = src;
				res.role       = smfb_pkg::ROLE_SOURCE;
				pec_d          = smfb_pkg::crc8_step(pec_q, src);
				phase_d        = smfb_pkg::PH_DATA;
			end
			smfb_pkg::PH_DATA: begin
				do_data = 1'b1;
			end
			smfb_pkg::PH_PEC: begin
				emit           = 1'b1;
				res.frame_byte = pec_q;
				res.role       = smfb_pkg::ROLE_PEC;
				res.frame_end  = 1'b1;
				res.mism       = (seen_q != decl_q);
				in_frame_d     = 1'b0;
				drop_d         = 1'b0;
			end
			default: begin
				phase_d = smfb_pkg::PH_NEW;
			end
		endcase

		// Payload step; a byte outside any packet is simply discarded.
		if (do_data && eff_in_frame) begin
			seen_d = (eff_seen == 8'hFF) ? eff_seen : eff_seen + 8'd1;
			if (!eff_drop) begin
				emit           = 1'b1;
				res.frame_byte = item.payload;
				res.role       = smfb_pkg::ROLE_PAYLOAD;
				pec_d          = smfb_pkg::crc8_step(eff_pec, item.payload);
			end
			if (item.last) begin
				if (!eff_drop) begin
					phase_d = smfb_pkg::PH_PEC;
				end else begin
					in_frame_d = 1'b0;
					drop_d     = 1'b0;
				end
			end
		end

		res.valid = item.valid && emit;
	end

	// A step that puts out a byte waits for room in the output register.
	assign fire = item.valid && (out_ok || !emit);
	assign done = fire && (phase_d == smfb_pkg::PH_NEW);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= smfb_pkg::PH_NEW;
			pec_q      <= 8'd0;
			seen_q     <= 8'd0;
			decl_q     <= 8'd0;
			in_frame_q <= 1'b0;
			drop_q     <= 1'b0;
		end else if (fire) begin
			phase_q    <= phase_d;
			pec_q      <= pec_d;
			seen_q     <= seen_d;
			decl_q     <= decl_d;
			in_frame_q <= in_frame_d;
			drop_q     <= drop_d;
		end
	end

endmodule

// File: rtl/smfb_out_reg.sv
// ---------------------------------------------------------------------------
// SMBus MCTP frame builder output register
// Holds one frame byte with its flags until the receiver takes it.
// ---------------------------------------------------------------------------
module smfb_out_reg (
	input  logic                clk,
	input  logic                arst_n,
	input  smfb_pkg::res_t      res,
	output logic                out_ok,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [7:0]          frame_byte,
	output logic [2:0]          byte_role,
	output logic                frame_end,
	output logic                length_mismatch
);

	logic       valid_q;
	logic [7:0] byte_q;
	logic [2:0] role_q;
	logic       end_q;
	logic       mism_q;

	// Room for a new byte when empty or when the held byte leaves now.
	assign out_ok = !valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (out_ok) begin
			valid_q <= res.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (out_ok && res.valid) begin
			byte_q <= res.frame_byte;
			role_q <= res.role;
			end_q  <= res.frame_end;
			mism_q <= res.mism;
		end
	end

	assign out_valid       = valid_q;
	assign frame_byte      = byte_q;
	assign byte_role       = role_q;
	assign frame_end       = end_q;
	assign length_mismatch = mism_q;

endmodule

// File: rtl/smbus_mctp_frame_builder.sv
// ---------------------------------------------------------------------------
// SMBus MCTP frame builder
// Wraps MCTP packet bytes into SMBus block-write frames with a CRC-8 PEC.
// ---------------------------------------------------------------------------
// Packet bytes enter one item at a time and leave as SMBus frame bytes, one
// frame byte per cycle while the receiver does not stall, through a single
// output register. A payload byte in the middle of an enabled packet yields
// only that byte, so a packet streams at one byte per clock when nothing stalls.
// The first byte of an enabled packet yields the command code, byte count,
// source address, then the byte itself, and the last byte yields the byte
// and then the PEC; a one-byte packet yields all five. Bytes of a dropped
// packet and stray bytes outside a packet produce nothing. The output
// register moves one frame byte per cycle unless stalled; the input register
// takes the next item in the same cycle in which the framer finishes the
// current one. The PEC covers the destination write address, the three
// header bytes and the payload, and the byte count is packet_length plus
// one, modulo 256. A first byte while a packet is open abandons that frame
// without a PEC. Configuration writes are taken at any time (cfg_ready is
// always high) but must only be made while the block is idle.
// ---------------------------------------------------------------------------
module smbus_mctp_frame_builder (
	input  logic        clk,
	input  logic        arst_n,

	// Packet byte input.
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  payload_byte,
	input  logic        first_byte,
	input  logic        final_byte,
	input  logic [7:0]  packet_length,

	// Frame byte output.
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  frame_byte,
	output logic [2:0]  byte_role,
	output logic        frame_end,
	output logic        length_mismatch,

	// Configuration write channel.
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [6:0]  cfg_data
);

	smfb_pkg::item_t item;
	smfb_pkg::cfg_t  cfg;
	smfb_pkg::res_t  res;
	logic            out_ok;
	logic            done;

	logic [6:0] source_address_q;
	logic [6:0] target_address_q;
	logic       target_enabled_q;

	// Configuration registers. Writes to an index beyond the list are ignored.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			source_address_q <= smfb_pkg::SOURCE_ADDRESS_RST;
			target_address_q <= smfb_pkg::TARGET_ADDRESS_RST;
			target_enabled_q <= smfb_pkg::TARGET_ENABLED_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				smfb_pkg::CFG_SOURCE_ADDRESS: source_address_q <= cfg_data;
				smfb_pkg::CFG_TARGET_ADDRESS: target_address_q <= cfg_data;
				smfb_pkg::CFG_TARGET_ENABLED: target_enabled_q <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		cfg.src = source_address_q;
		cfg.tgt = target_address_q;
		cfg.en  = target_enabled_q;
	end

	// Input register: holds the packet byte being framed.
	smfb_in_reg u_in_reg (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.payload_byte  (payload_byte),
		.first_byte    (first_byte),
		.final_byte    (final_byte),
		.packet_length (packet_length),
		.done          (done),
		.item          (item)
	);

	// Framer: packet state, running PEC and header/PEC sequencing.
	smfb_framer u_framer (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.cfg    (cfg),
		.out_ok (out_ok),
		.res    (res),
		.done   (done)
	);

	// Output register: one frame byte waits here for the receiver.
	smfb_out_reg u_out_reg (
		.clk             (clk),
		.arst_n          (arst_n),
		.res             (res),
		.out_ok          (out_ok),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.frame_byte      (frame_byte),
		.byte_role       (byte_role),
		.frame_end       (frame_end),
		.length_mismatch (length_mismatch)
	);

	// Only the PEC byte closes a frame.
	a_end_is_pec: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && frame_end |-> byte_role == smfb_pkg::ROLE_PEC)
		else $error("frame end flagged on a byte that is not the PEC");

	// A length mismatch is only reported on the frame's closing byte.
	a_mism_on_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && length_mismatch |-> frame_end)
		else $error("length mismatch flagged outside the PEC byte");

	// The input is only held off while an item occupies the input register.
	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> item.valid)
		else $error("input stalled with an empty input register");

	// A byte handed to a full, stalled output register would be lost.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |-> !(res.valid && done))
		else $error("framer finished an item into a stalled output register");

endmodule

// File: tb/smbus_mctp_frame_builder_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// SMBus MCTP frame builder checker
// Watches the packet, frame and configuration channels, predicts every frame
// byte from the accepted packet bytes and compares the output against it.
// ---------------------------------------------------------------------------
module smbus_mctp_frame_builder_checker
	import smfb_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,

	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [7:0]  payload_byte,
	input  logic        first_byte,
	input  logic        final_byte,
	input  logic [7:0]  packet_length,

	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [7:0]  frame_byte,
	input  logic [2:0]  byte_role,
	input  logic        frame_end,
	input  logic        length_mismatch,

	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [6:0]  cfg_data,

	input  logic        end_of_run,
	output int          outstanding,
	output int          fail_count,
	output int          bytes_checked
);

	typedef struct {
		logic [7:0] value;
		role_t      role;
		logic       ends;
		logic       mism;
	} frame_entry_t;

	frame_entry_t frame_bytes_due[$];

	// Shadow of the configuration registers.
	logic [6:0] own_addr;
	logic [6:0] peer_addr;
	logic       dest_on;

	// Shadow of the framing state.
	logic [7:0] pec;
	logic [7:0] seen;
	logic [7:0] declared;
	logic       pkt_open;
	logic       dropping;

	int errors;
	int checked;
	bit swept;

	assign fail_count    = errors;
	assign bytes_checked = checked;

	task automatic report(input string what);
		errors++;
		$display("[%0t] mismatch: %s", $time, what);
	endtask

	// CRC-8 over one byte, polynomial x^8 + x^2 + x + 1, one data bit at a time.
	function automatic logic [7:0] pec_add(input logic [7:0] crc, input logic [7:0] data);
		logic [7:0] r;
		logic       fb;
		r = crc;
		for (int b = 7; b >= 0; b--) begin
			fb = r[7] ^ data[b];
			r = {r[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
		end
		return r;
	endfunction

	task automatic queue_byte(input logic [7:0] value, input role_t role,
			input logic ends, input logic mism);
		frame_entry_t e;
		e.value = value;
		e.role  = role;
		e.ends  = ends;
		e.mism  = mism;
		frame_bytes_due.push_back(e);
	endtask

	// Frame bytes caused by one accepted packet byte.
	task automatic build_frame(input logic [7:0] data, input logic first,
			input logic last, input logic [7:0] plen);
		logic [7:0] count_byte;
		logic [7:0] src_byte;
		count_byte = plen + 8'd1;
		src_byte   = {own_addr, 1'b1};
		if (first) begin
			pkt_open = 1'b1;
			seen     = 8'd0;
			declared = plen;
			dropping = !dest_on;
			pec      = 8'd0;
			if (!dropping) begin
				pec = pec_add(8'd0, {peer_addr, 1'b0});
				pec = pec_add(pec, CMD_CODE);
				pec = pec_add(pec, count_byte);
				pec = pec_add(pec, src_byte);
				queue_byte(CMD_CODE, ROLE_CMD, 1'b0, 1'b0);
				queue_byte(count_byte, ROLE_COUNT, 1'b0, 1'b0);
				queue_byte(src_byte, ROLE_SOURCE, 1'b0, 1'b0);
			end
		end else if (!pkt_open) begin
			return;
		end
		if (seen != 8'hFF)
			seen = seen + 8'd1;
		if (!dropping) begin
			pec = pec_add(pec, data);
			queue_byte(data, ROLE_PAYLOAD, 1'b0, 1'b0);
		end
		if (last) begin
			if (!dropping)
				queue_byte(pec, ROLE_PEC, 1'b1, seen != declared);
			pkt_open = 1'b0;
			dropping = 1'b0;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : track
		frame_entry_t want;
		if (!arst_n) begin
			frame_bytes_due.delete();
			own_addr  = SOURCE_ADDRESS_RST;
			peer_addr = TARGET_ADDRESS_RST;
			dest_on   = TARGET_ENABLED_RST;
			pec       = 8'd0;
			seen      = 8'd0;
			declared  = 8'd0;
			pkt_open  = 1'b0;
			dropping  = 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_SOURCE_ADDRESS: own_addr = cfg_data;
					CFG_TARGET_ADDRESS: peer_addr = cfg_data;
					CFG_TARGET_ENABLED: dest_on = cfg_data[0];
					default: ;
				endcase
			end

			// Outputs are compared before this edge's input is predicted, so a
			// stray byte can never be matched against a fresh expectation.
			if (out_valid && !out_stall) begin
				checked++;
				if (frame_bytes_due.size() == 0) begin
					report($sformatf("unexpected frame byte %02h role %0d",
						frame_byte, byte_role));
				end else begin
					want = frame_bytes_due.pop_front();
					if (frame_byte !== want.value)
						report($sformatf("frame_byte %02h, expected %02h (role %0d)",
							frame_byte, want.value, want.role));
					if (byte_role !== want.role)
						report($sformatf("byte_role %0d, expected %0d",
							byte_role, want.role));
					if (frame_end !== want.ends)
						report($sformatf("frame_end %b, expected %b (role %0d)",
							frame_end, want.ends, want.role));
					if (length_mismatch !== want.mism)
						report($sformatf("length_mismatch %b, expected %b (role %0d)",
							length_mismatch, want.mism, want.role));
				end
			end

			if (in_valid && !in_stall)
				build_frame(payload_byte, first_byte, final_byte, packet_length);

			if (end_of_run && !swept) begin
				swept = 1'b1;
				if (frame_bytes_due.size() != 0)
					report($sformatf("%0d frame bytes never arrived",
						frame_bytes_due.size()));
			end
		end
		outstanding <= frame_bytes_due.size();
	end

endmodule

// File: tb/smbus_mctp_frame_builder_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// SMBus MCTP frame builder testbench
// Feeds MCTP packet bytes through the frame builder under changing address
// and enable settings, with random gaps and stalls on both sides, and leaves
// the frame byte checks to the checker instantiated beside the block.
// ---------------------------------------------------------------------------
module smbus_mctp_frame_builder_tb;
	import smfb_pkg::*;

	// Generous bound on the run. The slowest legal run is a few hundred
	// packet items, each worth up to five frame bytes that may each sit out the
	// longest drawn stall, plus a 258-byte packet and one long output hold.
	localparam int CYCLE_LIMIT  = 400_000;
	// Cycles allowed after the last expected frame byte for the block to
	// swallow any trailing bytes that make no output (dropped or stray).
	localparam int TAIL_CYCLES  = 12;
	// Length of the one long output hold that backs the block up.
	localparam int HOLD_CYCLES  = 300;
	// Fewest random packet items sent after the directed part. The first four
	// phases, which pin the extremes and serve the long hold, always run.
	localparam int RANDOM_ITEMS = 55;
	// Random phases that always run.
	localparam int MIN_PHASES   = 4;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;

	logic       in_valid = 1'b0;
	logic       in_stall;
	logic [7:0] payload_byte = 8'd0;
	logic       first_byte = 1'b0;
	logic       final_byte = 1'b0;
	logic [7:0] packet_length = 8'd0;

	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [7:0] frame_byte;
	logic [2:0] byte_role;
	logic       frame_end;
	logic       length_mismatch;

	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	logic [1:0] cfg_index = CFG_SOURCE_ADDRESS;
	logic [6:0] cfg_data = 7'd0;

	logic       end_of_run = 1'b0;
	int         outstanding;
	int         fail_count;
	int         bytes_checked;

	// Pacing controls shared between the sender and the receiver. When calm
	// is set a side never idles, which gives stretches of back-to-back items.
	bit         in_calm = 1'b0;
	bit         rx_calm = 1'b0;
	bit         hold_req = 1'b0;

	// Run bookkeeping for the summary.
	int         cycle_count = 0;
	int         packet_items = 0;
	int         settings_used = 0;
	int         holds_done = 0;
	bit         pkt_open = 1'b0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	smbus_mctp_frame_builder dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.payload_byte    (payload_byte),
		.first_byte      (first_byte),
		.final_byte      (final_byte),
		.packet_length   (packet_length),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.frame_byte      (frame_byte),
		.byte_role       (byte_role),
		.frame_end       (frame_end),
		.length_mismatch (length_mismatch),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data)
	);

	smbus_mctp_frame_builder_checker chk (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.payload_byte    (payload_byte),
		.first_byte      (first_byte),
		.final_byte      (final_byte),
		.packet_length   (packet_length),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.frame_byte      (frame_byte),
		.byte_role       (byte_role),
		.frame_end       (frame_end),
		.length_mismatch (length_mismatch),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.end_of_run      (end_of_run),
		.outstanding     (outstanding),
		.fail_count      (fail_count),
		.bytes_checked   (bytes_checked)
	);

	// Watchdog: a hung handshake ends the run here.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Run did not finish within %0d cycles", CYCLE_LIMIT);
			$display("Simulation FAILED");
			$finish;
		end
	end

	// Idle cycles before an item. Mostly short gaps, sometimes long ones,
	// none at all while the side is calm.
	function automatic int draw_gap(input bit calm);
		if (calm)
			return 0;
		if ($urandom_range(0, 2) == 0)
			return $urandom_range(0, 16);
		return $urandom_range(0, 2);
	endfunction

	// Packet sizes: mostly a handful of bytes, now and then a few dozen.
	function automatic int pick_len();
		if ($urandom_range(0, 9) == 0)
			return $urandom_range(9, 40);
		return $urandom_range(1, 8);
	endfunction

	// Offers one packet byte and returns at the edge that accepts it. Valid
	// stays high into the next item when no gap is drawn, so it is never
	// lowered and raised in the same step.
	task automatic send_item(input logic [7:0] data, input logic first,
			input logic last, input logic [7:0] plen);
		int gap;
		gap = draw_gap(in_calm);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid      <= 1'b1;
		payload_byte  <= data;
		first_byte    <= first;
		final_byte    <= last;
		packet_length <= plen;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		// Bytes outside any packet are ignored by the block and do not count.
		if (first)
			pkt_open = 1'b1;
		if (pkt_open)
			packet_items++;
		if (last)
			pkt_open = 1'b0;
	endtask

	// Sends n bytes of random content. The first byte declares the given
	// length; the last byte carries the final mark only when the packet is
	// closed, otherwise the next first byte restarts the frame.
	task automatic send_packet(input int n, input logic [7:0] declared, input bit closed);
		for (int k = 0; k < n; k++)
			send_item(8'($urandom), k == 0, closed && (k == n - 1),
				(k == 0) ? declared : 8'($urandom));
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [6:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
	endtask

	// All three registers are written each time so every setting is complete.
	task automatic program_regs(input logic [6:0] src, input logic [6:0] tgt, input logic en);
		write_reg(CFG_SOURCE_ADDRESS, src);
		write_reg(CFG_TARGET_ADDRESS, tgt);
		write_reg(CFG_TARGET_ENABLED, {6'd0, en});
		cfg_valid <= 1'b0;
		settings_used++;
	endtask

	// Brings the block to idle: no item offered, every expected frame byte
	// delivered, then a few cycles for bytes that produce nothing. The first
	// edge lets the checker's count catch up with the last accepted item.
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
	endtask

	// Receiver: draws a stall before each frame byte, and once serves a long
	// hold on request so the block backs up into its input.
	initial begin : drain_side
		int gap;
		wait (arst_n === 1'b1);
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				holds_done++;
			end else begin
				gap = draw_gap(rx_calm);
				if (gap > 0) begin
					out_stall <= 1'b1;
					repeat (gap) @(posedge clk);
				end
			end
			out_stall <= 1'b0;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
		end
	end

	// Stimulus and verdict.
	initial begin : stimulus
		int random_start;
		int phase;
		int kind;
		int len;
		logic [6:0] src;
		logic [6:0] tgt;
		logic       en;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part, first under the reset settings.
		// A one-byte packet gives the full header, the byte and the PEC.
		send_item(8'h00, 1'b1, 1'b1, 8'd1);
		// A well-formed three-byte packet with the extreme byte values.
		send_item(8'hFF, 1'b1, 1'b0, 8'd3);
		send_item(8'hA5, 1'b0, 1'b0, 8'h00);
		send_item(8'h5A, 1'b0, 1'b1, 8'hFF);
		// Declared length 255 wraps the byte count to zero and mismatches.
		send_item(8'h3C, 1'b1, 1'b1, 8'd255);
		// Declared length zero: count of one, mismatch flagged.
		send_item(8'hC3, 1'b1, 1'b1, 8'd0);
		// Largest legal declared length on a short packet.
		send_item(8'h01, 1'b1, 1'b0, 8'd254);
		send_item(8'h80, 1'b0, 1'b1, 8'd0);
		// Stray bytes with no open packet are ignored, last mark or not.
		send_item(8'h55, 1'b0, 1'b0, 8'hAA);
		send_item(8'hAA, 1'b0, 1'b1, 8'h55);
		// A new first byte abandons the open frame with no PEC.
		send_item(8'h12, 1'b1, 1'b0, 8'd2);
		send_item(8'h34, 1'b1, 1'b0, 8'd2);
		send_item(8'h56, 1'b0, 1'b1, 8'd2);
		settle();

		// Destination disabled: the whole packet vanishes, including its last
		// byte, and a stray byte after it stays silent too.
		program_regs(7'd127, 7'd127, 1'b0);
		send_item(8'h77, 1'b1, 1'b0, 8'd2);
		send_item(8'h88, 1'b0, 1'b1, 8'd0);
		send_item(8'h99, 1'b0, 1'b1, 8'd0);
		settle();

		// Lowest addresses, destination back on.
		program_regs(7'd0, 7'd0, 1'b1);
		send_item(8'hE7, 1'b1, 1'b1, 8'd1);
		settle();

		// A packet longer than the byte counter can hold: the count sticks at
		// 255, so a declared length of 255 must not be flagged.
		in_calm = 1'b1;
		rx_calm = 1'b1;
		send_packet(258, 8'd255, 1'b1);
		in_calm = 1'b0;
		rx_calm = 1'b0;
		settle();

		// Random part: phases of packets, each under a fresh setting. The
		// first phases pin the address extremes and a disabled destination;
		// one phase asks the receiver for a long hold while the sender keeps
		// pushing, so the block fills and stalls its input.
		random_start = packet_items;
		phase = 0;
		while (phase < MIN_PHASES || packet_items - random_start < RANDOM_ITEMS) begin
			settle();
			case (phase)
				0: begin src = 7'd127; tgt = 7'd0;   en = 1'b1; end
				1: begin src = 7'd0;   tgt = 7'd127; en = 1'b1; end
				2: begin src = 7'($urandom); tgt = 7'($urandom); en = 1'b0; end
				default: begin
					src = 7'($urandom);
					tgt = 7'($urandom);
					en  = ($urandom_range(0, 5) != 0);
				end
			endcase
			program_regs(src, tgt, en);

			in_calm = (phase % 4 == 1);
			rx_calm = (phase % 5 == 2);
			if (phase == 3) begin
				in_calm  = 1'b1;
				hold_req = 1'b1;
			end

			repeat ($urandom_range(1, 3)) begin
				kind = $urandom_range(0, 9);
				len  = pick_len();
				if (kind <= 6) begin
					// Well-formed packet.
					send_packet(len, 8'(len), 1'b1);
				end else if (kind == 7) begin
					// Declared length drawn over the whole field.
					send_packet(len, 8'($urandom), 1'b1);
				end else if (kind == 8) begin
					// Cut short by a restart, then a complete packet.
					send_packet(len, 8'(len), 1'b0);
					len = pick_len();
					send_packet(len, 8'(len), 1'b1);
				end else begin
					// Noise between packets.
					repeat ($urandom_range(1, 3))
						send_item(8'($urandom), 1'b0, 1'($urandom), 8'($urandom));
				end
			end
			phase++;
		end
		in_calm = 1'b0;
		rx_calm = 1'b0;
		settle();

		// Ask the checker for leftover expectations, then give the verdict.
		end_of_run <= 1'b1;
		repeat (3) @(posedge clk);
		$display("Run covered %0d packet items (%0d random) in %0d phases, %0d settings,",
			packet_items, packet_items - random_start, phase, settings_used);
		$display("%0d frame bytes checked, %0d long output holds, %0d cycles.",
			bytes_checked, holds_done, cycle_count);
		if (fail_count == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("%0d mismatches found", fail_count);
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
